/* hw/rtl/hmbs_pkg.sv */
// Package for the heightmap bilinear sampler.
// It holds field widths, opcodes, register indexes and reset values.
// It is used by all the other files of the block.
`default_nettype none

package hmbs_pkg;

    localparam int POS_W      = 24;
    localparam int HGT_W      = 24;
    localparam int OUT_W      = 32;
    localparam int FRAC_W     = 8;
    localparam int ROW_W      = 9;
    localparam int INV_W      = 24;
    localparam int VS_W       = 16;
    localparam int EXT_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = POS_W + INV_W + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [INV_W-1:0]        INV_HSCALE_RST = 24'd16646;
    localparam logic [VS_W-1:0]         VSCALE_RST     = 16'd768;
    localparam logic signed [HGT_W-1:0] OFFSET_RST     = 24'sd0;
    localparam logic [EXT_W-1:0]        EXTENT_RST     = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_HSCALE = 3'd0,
        CFG_VSCALE     = 3'd1,
        CFG_OFFSET     = 3'd2,
        CFG_GRID_ROWS  = 3'd3,
        CFG_GRID_COLS  = 3'd4
    } t_cfg_idx;

    typedef logic signed [HGT_W-1:0] t_height;

endpackage

`default_nettype wire

/* hw/rtl/hmbs_bank.sv */
// One bank of the height store: a synchronous memory with one write port
// and one read port whose data is registered. Uses hmbs_pkg for the sample type.
`default_nettype none

module hmbs_bank
    import hmbs_pkg::*;
#(
    parameter int AW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_height       i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_height            o_rd_data
);

    t_height r_mem [2**AW];
    t_height r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/hmbs_locate.sv */
// Maps one scaled coordinate to its floor and ceiling cells, clamped to the
// grid extent, and to its Q0.8 fraction. Uses hmbs_pkg for widths.
`default_nettype none

module hmbs_locate
    import hmbs_pkg::*;
#(
    parameter int MAX_SIDE = 512,
    localparam int CW = ($clog2(MAX_SIDE) < 2) ? 2 : $clog2(MAX_SIDE),
    localparam int EW = $clog2(MAX_SIDE + 1)
) (
    input  wire logic signed [PROD_W-1:0] i_prod,
    input  wire logic [EW-1:0]            i_ext,
    output logic [CW-1:0]                 o_c0,
    output logic [CW-1:0]                 o_c1,
    output logic [FRAC_W-1:0]             o_frac
);

    localparam int P_W = PROD_W - 16 + 1;
    localparam int F_W = P_W - FRAC_W;

    logic signed [P_W-1:0] p;
    logic signed [F_W-1:0] f;
    logic signed [F_W:0]   f_ext;
    logic signed [F_W:0]   cl;
    logic signed [F_W:0]   lim;
    logic [F_W:0]          inc;

    function automatic logic [CW-1:0] clamp_cell(input logic signed [F_W:0] v,
                                                 input logic signed [F_W:0] hi);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > hi) begin
            res = hi[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    assign p     = P_W'(i_prod >>> 16) + $signed(P_W'({i_ext >> 1, 8'd0}));
    assign f     = p[P_W-1:FRAC_W];
    assign f_ext = {f[F_W-1], f};
    assign inc   = {{F_W{1'b0}}, |p[FRAC_W-1:0]};
    assign cl    = f_ext + $signed(inc);
    assign lim   = $signed((F_W+1)'(i_ext - 1'b1));

    assign o_c0   = clamp_cell(f_ext, lim);
    assign o_c1   = clamp_cell(cl, lim);
    assign o_frac = p[FRAC_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/heightmap_bilinear_sampler.sv */
// Heightmap bilinear sampler: a height store written one sample per item,
// and queries that return the clamped bilinear blend of four samples.
// Throughput: one item per cycle unless i_stall holds the pipeline; the
// store is split into four banks by row and column parity, each read once
// per query. Reset clears the pipeline and the registers to defaults; the
// store is undefined until written.
`default_nettype none

module heightmap_bilinear_sampler
    import hmbs_pkg::*;
#(
    parameter int MAX_SIDE = 512
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_opcode,
    input  wire logic [ROW_W-1:0]        i_row_index,
    input  wire logic [ROW_W-1:0]        i_col_index,
    input  wire logic signed [HGT_W-1:0] i_height_value,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_sampled_height,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW   = ($clog2(MAX_SIDE) < 2) ? 2 : $clog2(MAX_SIDE);
    localparam int EW   = $clog2(MAX_SIDE + 1);
    localparam int HW   = CW - 1;
    localparam int AW   = 2 * HW;
    localparam int S_W  = HGT_W + 1 + VS_W + 1;
    localparam int TB_W = S_W + FRAC_W + 3;
    localparam int T_W  = TB_W + FRAC_W + 3;

    // Configuration registers.
    logic [INV_W-1:0]        r_inv_hscale;
    logic [VS_W-1:0]         r_vscale;
    logic signed [HGT_W-1:0] r_offset;
    logic [EXT_W-1:0]        r_grid_rows;
    logic [EXT_W-1:0]        r_grid_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_hscale <= INV_HSCALE_RST;
            r_vscale     <= VSCALE_RST;
            r_offset     <= OFFSET_RST;
            r_grid_rows  <= EXTENT_RST;
            r_grid_cols  <= EXTENT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INV_HSCALE: r_inv_hscale <= i_cfg_data[INV_W-1:0];
                CFG_VSCALE:     r_vscale     <= i_cfg_data[VS_W-1:0];
                CFG_OFFSET:     r_offset     <= $signed(i_cfg_data[HGT_W-1:0]);
                CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data[EXT_W-1:0];
                CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [EW-1:0] ext_rows;
    logic [EW-1:0] ext_cols;

    always_comb begin
        if (r_grid_rows == '0) begin
            ext_rows = EW'(1);
        end else if (int'(r_grid_rows) > MAX_SIDE) begin
            ext_rows = EW'(MAX_SIDE);
        end else begin
            ext_rows = EW'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            ext_cols = EW'(1);
        end else if (int'(r_grid_cols) > MAX_SIDE) begin
            ext_cols = EW'(MAX_SIDE);
        end else begin
            ext_cols = EW'(r_grid_cols);
        end
    end

    // Pipeline flow control: a stage takes new data when it is empty or
    // when its content moves on in the same cycle.
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid, r_o_valid;
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;
    logic in_xfer;

    assign en_o    = !r_o_valid || !i_stall;
    assign en_f    = !r_f_valid || en_o;
    assign en_e    = !r_e_valid || en_f;
    assign en_d    = !r_d_valid || en_e;
    assign en_c    = !r_c_valid || en_d;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_stall = !en_a;
    assign in_xfer = i_valid && en_a;

    // Stage A: position times inverse horizontal scale.
    logic                     r_a_op;
    logic [ROW_W-1:0]         r_a_row;
    logic [ROW_W-1:0]         r_a_col;
    t_height                  r_a_hgt;
    logic signed [PROD_W-1:0] r_a_prod_x;
    logic signed [PROD_W-1:0] r_a_prod_y;

    // Stage B: cells and fractions; the store is written or read here.
    logic                r_b_op;
    logic [ROW_W-1:0]    r_b_row;
    logic [ROW_W-1:0]    r_b_col;
    t_height             r_b_hgt;
    logic [CW-1:0]       r_b_x0, r_b_x1, r_b_y0, r_b_y1;
    logic [FRAC_W-1:0]   r_b_ax, r_b_ay;
    logic [CW-1:0]       loc_x0, loc_x1, loc_y0, loc_y1;
    logic [FRAC_W-1:0]   loc_ax, loc_ay;

    hmbs_locate #(.MAX_SIDE(MAX_SIDE)) u_locate_x (
        .i_prod (r_a_prod_x),
        .i_ext  (ext_rows),
        .o_c0   (loc_x0),
        .o_c1   (loc_x1),
        .o_frac (loc_ax)
    );

    hmbs_locate #(.MAX_SIDE(MAX_SIDE)) u_locate_y (
        .i_prod (r_a_prod_y),
        .i_ext  (ext_cols),
        .o_c0   (loc_y0),
        .o_c1   (loc_y1),
        .o_frac (loc_ay)
    );

    // Four banks by row and column parity.
    logic [CW-1:0]  wr_row, wr_col;
    logic           wr_ok;
    logic           rd_en;
    logic [3:0]     wr_en;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr [4];
    t_height        rd_data [4];

    assign wr_row  = CW'(r_b_row);
    assign wr_col  = CW'(r_b_col);
    assign wr_ok   = (int'(r_b_row) < MAX_SIDE) && (int'(r_b_col) < MAX_SIDE);
    assign wr_addr = {wr_row[CW-1:1], wr_col[CW-1:1]};
    assign rd_en   = en_c && r_b_valid && (r_b_op == OP_QUERY);

    for (genvar g = 0; g < 4; g++) begin : g_bank
        localparam logic PR = 1'(g >> 1);
        localparam logic PC = 1'(g & 1);
        logic [CW-1:0] rsel;
        logic [CW-1:0] csel;

        assign rsel       = (r_b_x0[0] == PR) ? r_b_x0 : r_b_x1;
        assign csel       = (r_b_y0[0] == PC) ? r_b_y0 : r_b_y1;
        assign rd_addr[g] = {rsel[CW-1:1], csel[CW-1:1]};
        assign wr_en[g]   = en_c && r_b_valid && (r_b_op == OP_WRITE) && wr_ok
                            && (wr_row[0] == PR) && (wr_col[0] == PC);

        hmbs_bank #(.AW(AW)) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_addr),
            .i_wr_data (r_b_hgt),
            .i_rd_en   (rd_en),
            .i_rd_addr (rd_addr[g]),
            .o_rd_data (rd_data[g])
        );
    end

    // Stage C: raw samples from the banks, routed by cell parity.
    logic              r_c_x0b, r_c_x1b, r_c_y0b, r_c_y1b;
    logic [FRAC_W-1:0] r_c_ax, r_c_ay;

    function automatic logic signed [S_W-1:0] scale_height(input t_height h,
                                                           input t_height off,
                                                           input logic [VS_W-1:0] vs);
        logic signed [HGT_W:0] d;
        d = $signed({h[HGT_W-1], h}) - $signed({off[HGT_W-1], off});
        return d * $signed({1'b0, vs});
    endfunction

    // Stage D: offset removed and vertical scale applied.
    logic signed [S_W-1:0] r_d_s00, r_d_s10, r_d_s01, r_d_s11;
    logic [FRAC_W-1:0]     r_d_ax, r_d_ay;
    logic [FRAC_W:0]       wx0;

    assign wx0 = (FRAC_W+1)'(9'd256 - {1'b0, r_d_ax});

    // Stage E: blend along rows.
    logic signed [TB_W-1:0] r_e_top, r_e_bot;
    logic [FRAC_W-1:0]      r_e_ay;
    logic [FRAC_W:0]        wy0;

    assign wy0 = (FRAC_W+1)'(9'd256 - {1'b0, r_e_ay});

    // Stage F: blend along columns.
    logic signed [T_W-1:0] r_f_t;
    logic signed [T_W-1:0] rnd;
    logic signed [T_W-1:0] shr;
    logic signed [OUT_W-1:0] sat;

    assign rnd = r_f_t + $signed(T_W'(64'h0080_0000));
    assign shr = rnd >>> 24;

    always_comb begin
        if (shr > $signed(T_W'(64'h7FFF_FFFF))) begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (shr < -$signed(T_W'(64'h8000_0000))) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = shr[OUT_W-1:0];
        end
    end

    // Output stage.
    logic signed [OUT_W-1:0] r_o_data;

    assign o_valid          = r_o_valid;
    assign o_sampled_height = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= in_xfer;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid && (r_b_op == OP_QUERY);
            end
            if (en_d) begin
                r_d_valid <= r_c_valid;
            end
            if (en_e) begin
                r_e_valid <= r_d_valid;
            end
            if (en_f) begin
                r_f_valid <= r_e_valid;
            end
            if (en_o) begin
                r_o_valid <= r_f_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_op     <= i_opcode;
            r_a_row    <= i_row_index;
            r_a_col    <= i_col_index;
            r_a_hgt    <= i_height_value;
            r_a_prod_x <= i_pos_x * $signed({1'b0, r_inv_hscale});
            r_a_prod_y <= i_pos_y * $signed({1'b0, r_inv_hscale});
        end
        if (en_b) begin
            r_b_op  <= r_a_op;
            r_b_row <= r_a_row;
            r_b_col <= r_a_col;
            r_b_hgt <= r_a_hgt;
            r_b_x0  <= loc_x0;
            r_b_x1  <= loc_x1;
            r_b_y0  <= loc_y0;
            r_b_y1  <= loc_y1;
            r_b_ax  <= loc_ax;
            r_b_ay  <= loc_ay;
        end
        if (en_c) begin
            r_c_x0b <= r_b_x0[0];
            r_c_x1b <= r_b_x1[0];
            r_c_y0b <= r_b_y0[0];
            r_c_y1b <= r_b_y1[0];
            r_c_ax  <= r_b_ax;
            r_c_ay  <= r_b_ay;
        end
        if (en_d) begin
            r_d_s00 <= scale_height(rd_data[{r_c_x0b, r_c_y0b}], r_offset, r_vscale);
            r_d_s10 <= scale_height(rd_data[{r_c_x1b, r_c_y0b}], r_offset, r_vscale);
            r_d_s01 <= scale_height(rd_data[{r_c_x0b, r_c_y1b}], r_offset, r_vscale);
            r_d_s11 <= scale_height(rd_data[{r_c_x1b, r_c_y1b}], r_offset, r_vscale);
            r_d_ax  <= r_c_ax;
            r_d_ay  <= r_c_ay;
        end
        if (en_e) begin
            r_e_top <= r_d_s00 * $signed({1'b0, wx0}) + r_d_s10 * $signed({2'b0, r_d_ax});
            r_e_bot <= r_d_s01 * $signed({1'b0, wx0}) + r_d_s11 * $signed({2'b0, r_d_ax});
            r_e_ay  <= r_d_ay;
        end
        if (en_f) begin
            r_f_t <= r_e_top * $signed({1'b0, wy0}) + r_e_bot * $signed({2'b0, r_e_ay});
        end
        if (en_o) begin
            r_o_data <= sat;
        end
    end

`ifndef ASSERT_OFF
    a_bank_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && (wr_en != 4'b0000)))
        else $error("bank read and write in the same cycle");

    a_one_bank_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_en))
        else $error("more than one bank written by one item");

    a_cells_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && (r_b_op == OP_QUERY) |->
            ((r_b_x1 == r_b_x0) || ({1'b0, r_b_x1} == {1'b0, r_b_x0} + 1'b1)) &&
            ((r_b_y1 == r_b_y0) || ({1'b0, r_b_y1} == {1'b0, r_b_y0} + 1'b1)))
        else $error("ceiling cell is not the floor cell or its neighbor");

    a_query_reaches_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> r_c_valid)
        else $error("query read from the store was lost");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_valid && r_o_valid && i_stall)
        else $error("input stalled while the pipeline had room");
`endif

endmodule

`default_nettype wire
